// ----- src/fpc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpc_pkg: shared constants for the 5x5 fuzzy PD controller
// Sample width, output limits, queue depth and the rule consequent table.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int DATA_W        = 16;
  localparam int NUM_SETS      = 5;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 16'sh8000;

  // consequent center in half units (-2 = NB .. +2 = PB), [e set][de set]
  localparam int RULE_OFS [NUM_SETS][NUM_SETS] = '{
    '{-2, -2, -1, -1,  0},
    '{-2, -1, -1,  0,  1},
    '{-1, -1,  0,  1,  1},
    '{-1,  0,  1,  1,  2},
    '{ 0,  1,  1,  2,  2}
  };

endpackage

`default_nettype wire

// ----- src/fpc_front.sv -----
// ----------------------------------------------------------------------------
// fpc_front: request intake and fuzzifier
// Takes a request when the queue has room and grades both samples against
// the five sets NB..PB, triangular inside and shouldered at NB and PB.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_front import fpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                          start_i,
  input  logic                                          q_full_i,
  input  logic signed [DATA_W-1:0]                      error_sample_i,
  input  logic signed [DATA_W-1:0]                      error_change_i,
  output logic                                          push_o,
  output logic [1:0][NUM_SETS-1:0][FRAC_BITS:0]         grades_o
);

  localparam int GW     = FRAC_BITS + 1;
  localparam int XW     = (FRAC_BITS + 3 > 18) ? FRAC_BITS + 3 : 18;
  localparam int HALF_I = 2 ** (FRAC_BITS - 1);

  function automatic logic [GW-1:0] grade(input logic signed [DATA_W-1:0] x, input int k);
    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] c;
    logic signed [XW-1:0] d;
    logic [XW-1:0]        ad;
    logic [XW-1:0]        diff;
    xe   = XW'(x);
    c    = XW'((k - 2) * HALF_I);
    d    = xe - c;
    ad   = d[XW-1] ? $unsigned(-d) : $unsigned(d);
    diff = $unsigned(XW'(HALF_I)) - ad;
    if (k == 0 && xe <= c) begin
      return GW'(1) << FRAC_BITS;
    end else if (k == NUM_SETS - 1 && xe >= c) begin
      return GW'(1) << FRAC_BITS;
    end else if (ad >= $unsigned(XW'(HALF_I))) begin
      return '0;
    end else begin
      return {diff[FRAC_BITS-1:0], 1'b0};
    end
  endfunction

  assign push_o = start_i && !q_full_i;

  for (genvar k = 0; k < NUM_SETS; k++) begin : g_sets
    assign grades_o[0][k] = grade(error_sample_i, k);
    assign grades_o[1][k] = grade(error_change_i, k);
  end

endmodule

`default_nettype wire

// ----- src/fpc_queue.sv -----
// ----------------------------------------------------------------------------
// fpc_queue: short fifo between front and back
// Holds graded requests between the fuzzifier and the rule datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_queue import fpc_pkg::*; #(
  parameter int WIDTH = 2 * NUM_SETS * (FRAC_BITS_DEF + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/fpc_rules.sv -----
// ----------------------------------------------------------------------------
// fpc_rules: rule firing and aggregation
// Min of grade pairs for all 25 rules, per-consequent sums, then the
// weighted center sum and the total weight, over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_rules import fpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic [1:0][NUM_SETS-1:0][FRAC_BITS:0] grades_i,
  output logic                                  valid_o,
  output logic signed [FRAC_BITS+6:0]           sum_o,
  output logic [FRAC_BITS+4:0]                  den_o
);

  localparam int GW  = FRAC_BITS + 1;
  localparam int GSW = FRAC_BITS + 5;
  localparam int SW  = FRAC_BITS + 7;

  logic [NUM_SETS-1:0][NUM_SETS-1:0][GW-1:0] w_q, w_d;
  logic [NUM_SETS-1:0][GSW-1:0]              grp_q, grp_d;
  logic signed [SW-1:0]                      sum_q, sum_d;
  logic [GSW-1:0]                            den_q, den_d;
  logic                                      v1_q, v2_q, v3_q;

  // rule strength
  always_comb begin
    for (int i = 0; i < NUM_SETS; i++) begin
      for (int j = 0; j < NUM_SETS; j++) begin
        w_d[i][j] = (grades_i[0][i] < grades_i[1][j]) ? grades_i[0][i] : grades_i[1][j];
      end
    end
  end

  // weight per consequent set
  always_comb begin
    for (int o = 0; o < NUM_SETS; o++) begin
      grp_d[o] = '0;
      for (int i = 0; i < NUM_SETS; i++) begin
        for (int j = 0; j < NUM_SETS; j++) begin
          if (RULE_OFS[i][j] == o - 2) begin
            grp_d[o] = grp_d[o] + GSW'(w_q[i][j]);
          end
        end
      end
    end
  end

  always_comb begin
    den_d = grp_q[0] + grp_q[1] + grp_q[2] + grp_q[3] + grp_q[4];
    sum_d = ((SW'(grp_q[4]) - SW'(grp_q[0])) << 1) + SW'(grp_q[3]) - SW'(grp_q[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    grp_q <= grp_d;
    sum_q <= sum_d;
    den_q <= den_d;
  end

  assign valid_o = v3_q;
  assign sum_o   = sum_q;
  assign den_o   = den_q;

endmodule

`default_nettype wire

// ----- src/fpc_div.sv -----
// ----------------------------------------------------------------------------
// fpc_div: center-of-gravity divider
// Pipelined restoring divider, one quotient bit per stage, rounding to
// nearest with ties away from zero, then sign and 16-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_div import fpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [FRAC_BITS+6:0] sum_i,
  input  logic [FRAC_BITS+4:0]        den_i,
  output logic                        done_o,
  output logic signed [DATA_W-1:0]    value_o
);

  localparam int SW = FRAC_BITS + 7;
  localparam int DW = FRAC_BITS + 5;
  localparam int MW = 2 * FRAC_BITS + 6;
  localparam int QW = FRAC_BITS + 2;
  localparam int RW = (QW + 1 > DATA_W + 1) ? QW + 1 : DATA_W + 1;

  localparam logic signed [RW-1:0] SAT_MAX = RW'(DATA_MAX);
  localparam logic signed [RW-1:0] SAT_MIN = RW'(DATA_MIN);

  logic [SW-1:0]        mag;
  logic [MW-1:0]        n_d;
  logic [MW-1:0]        rem_q [QW+1];
  logic [QW-1:0]        quo_q [QW+1];
  logic [DW-1:0]        den_q [QW+1];
  logic                 neg_q [QW+1];
  logic                 zro_q [QW+1];
  logic                 vld_q [QW+1];
  logic [MW-1:0]        trial [QW];
  logic                 fits  [QW];
  logic signed [RW-1:0] res;
  logic signed [DATA_W-1:0] value_d, value_q;
  logic                 done_q;

  always_comb begin
    mag = sum_i[SW-1] ? $unsigned(-sum_i) : $unsigned(sum_i);
    n_d = (MW'(mag) << (FRAC_BITS - 1)) + MW'(den_i >> 1);
  end

  always_comb begin
    for (int s = 0; s < QW; s++) begin
      trial[s] = MW'(den_q[s]) << (QW - 1 - s);
      fits[s]  = (rem_q[s] >= trial[s]);
    end
  end

  always_comb begin
    res = neg_q[QW] ? -$signed(RW'(quo_q[QW])) : $signed(RW'(quo_q[QW]));
    if (zro_q[QW]) begin
      value_d = '0;
    end else if (res > SAT_MAX) begin
      value_d = DATA_MAX;
    end else if (res < SAT_MIN) begin
      value_d = DATA_MIN;
    end else begin
      value_d = res[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QW; s++) begin
        vld_q[s] <= 1'b0;
      end
      done_q <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int s = 0; s < QW; s++) begin
        vld_q[s+1] <= vld_q[s];
      end
      done_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= n_d;
    quo_q[0] <= '0;
    den_q[0] <= den_i;
    neg_q[0] <= sum_i[SW-1];
    zro_q[0] <= (den_i == '0);
    for (int s = 0; s < QW; s++) begin
      rem_q[s+1] <= fits[s] ? rem_q[s] - trial[s] : rem_q[s];
      quo_q[s+1] <= {quo_q[s][QW-2:0], fits[s]};
      den_q[s+1] <= den_q[s];
      neg_q[s+1] <= neg_q[s];
      zro_q[s+1] <= zro_q[s];
    end
    value_q <= value_d;
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

`default_nettype wire

// ----- src/fuzzy_pd_controller_5x5.sv -----
// ----------------------------------------------------------------------------
// fuzzy_pd_controller_5x5: two-input Mamdani fuzzy controller, 25 rules
// Throughput: one request per clock while busy_o is low, which is every clock.
// Path: the queue, the rule stages, then the bit-per-stage divider and its
// output register; done_o rises with the result on drive_value_o, and most
// of the depth is in the divider. busy_o stays low since the back never stalls.
// Reset clears queue and pipeline valids; no requests are lost mid-flight after it.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_pd_controller_5x5 import fpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [DATA_W-1:0] error_sample_i,
  input  logic signed [DATA_W-1:0] error_change_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] drive_value_o
);

  localparam int QWIDTH = 2 * NUM_SETS * (FRAC_BITS + 1);

  logic                                  push;
  logic                                  q_full;
  logic                                  q_valid;
  logic [1:0][NUM_SETS-1:0][FRAC_BITS:0] grades_in;
  logic [1:0][NUM_SETS-1:0][FRAC_BITS:0] grades_out;
  logic                                  agg_valid;
  logic signed [FRAC_BITS+6:0]           agg_sum;
  logic [FRAC_BITS+4:0]                  agg_den;

  fpc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .start_i        (start_i),
    .q_full_i       (q_full),
    .error_sample_i (error_sample_i),
    .error_change_i (error_change_i),
    .push_o         (push),
    .grades_o       (grades_in)
  );

  fpc_queue #(.WIDTH(QWIDTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (grades_in),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .data_o  (grades_out),
    .full_o  (q_full)
  );

  fpc_rules #(.FRAC_BITS(FRAC_BITS)) u_rules (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .grades_i (grades_out),
    .valid_o  (agg_valid),
    .sum_o    (agg_sum),
    .den_o    (agg_den)
  );

  fpc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (agg_valid),
    .sum_i   (agg_sum),
    .den_i   (agg_den),
    .done_o  (done_o),
    .value_o (drive_value_o)
  );

  assign busy_o = q_full;

endmodule

`default_nettype wire

// ----- src/fpc_checker.sv -----
// ----------------------------------------------------------------------------
// fpc_checker: port-level checks for the fuzzy controller
// Fixed latency, no spurious results, output range and zero-in zero-out.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_checker import fpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic signed [DATA_W-1:0] error_sample_i,
  input logic signed [DATA_W-1:0] error_change_i,
  input logic                     done_o,
  input logic signed [DATA_W-1:0] drive_value_o
);

  localparam int LAT = FRAC_BITS + 8;
  localparam int LIM = (FRAC_BITS > 14) ? 32767 : (1 << FRAC_BITS);

  logic acc;

  assign acc = start_i && !busy_o;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT done_o)
    else $error("request without result at fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, LAT))
    else $error("result without matching request");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (drive_value_o <= LIM && drive_value_o >= -LIM))
    else $error("drive value out of range");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && error_sample_i == '0 && error_change_i == '0) |-> ##LAT (drive_value_o == '0))
    else $error("zero inputs must give zero drive");

endmodule

bind fuzzy_pd_controller_5x5 fpc_checker #(.FRAC_BITS(FRAC_BITS)) u_fpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .error_sample_i (error_sample_i),
  .error_change_i (error_change_i),
  .done_o         (done_o),
  .drive_value_o  (drive_value_o)
);

`default_nettype wire
